### sv/ata_sector_address_translate_defines.svh
// Assertion macros for the sector address translation checker.
// Used by asat_chk.sv; needs i_clk and i_rst_n in the scope of each use.
`ifndef ATA_SECTOR_ADDRESS_TRANSLATE_DEFINES_SVH
`define ATA_SECTOR_ADDRESS_TRANSLATE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ASAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/asat_pkg.sv
// Shared types and constants for the ATA sector address translation block.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package asat_pkg;

    // Field widths
    localparam int SECTOR_W = 32;
    localparam int SPT_W    = 8;
    localparam int HC_W     = 5;
    localparam int CYL_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int OUT_W    = 5 * BYTE_W;   // five task-file bytes
    localparam int CFG_IDX_W = 3;

    // Quotient bits resolved per divider stage
    localparam int DIV_BPS = 4;

    // Task-file constants
    localparam logic [BYTE_W-1:0] BASE_CHS  = 8'hA0;
    localparam logic [BYTE_W-1:0] BASE_LBA  = 8'hE0;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h21;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h31;
    localparam logic [BYTE_W-1:0] SLAVE_BIT = 8'h10;

    // Reset geometry
    localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
    localparam logic [HC_W-1:0]  HC_RESET  = 5'd16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LBA_MODE     = 3'd0,
        CFG_SPT          = 3'd1,
        CFG_HEAD_COUNT   = 3'd2,
        CFG_SECTOR_LIMIT = 3'd3,
        CFG_SLAVE_SELECT = 3'd4,
        CFG_CD_DEVICE    = 3'd5
    } t_cfg_idx;

    // Request info carried alongside the first division
    typedef struct packed {
        logic                ok;
        logic                func;
        logic [SECTOR_W-1:0] sector;
    } t_side1;

    // Request info carried alongside the second division
    typedef struct packed {
        logic                ok;
        logic                func;
        logic [SECTOR_W-1:0] sector;
        logic [SPT_W-1:0]    srem;     // sector within track, zero-based
    } t_side2;

endpackage

### sv/asat_div.sv
// Pipelined restoring divider with a sideband word that travels with each item.
// Standalone; instantiated twice by ata_sector_address_translate.
`timescale 1ns / 1ps

module asat_div #(
    parameter int DW  = 32,    // dividend width
    parameter int VW  = 8,     // divisor width
    parameter int SW  = 1,     // sideband width
    parameter int BPS = 4      // quotient bits per stage
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,   // must be nonzero
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    localparam int NS = (DW + BPS - 1) / BPS;

    logic          r_v    [NS];
    logic          w_load [NS];
    logic [VW-1:0] r_rem  [NS];
    logic [DW-1:0] r_work [NS];     // dividend bits still to go, quotient bits shifted in
    logic [VW-1:0] r_dsr  [NS];
    logic [SW-1:0] r_side [NS];

    // A stage loads when it is empty or its contents move on this cycle
    assign w_load[NS-1] = !r_v[NS-1] || i_ready;
    generate
        for (genvar s = 0; s < NS - 1; s++) begin : g_load
            assign w_load[s] = !r_v[s] || w_load[s+1];
        end
    endgenerate

    assign o_ready = w_load[0];

    generate
        for (genvar s = 0; s < NS; s++) begin : g_stage
            localparam int LEFT  = DW - s * BPS;
            localparam int STEPS = (LEFT < BPS) ? LEFT : BPS;

            logic          a_v;
            logic [VW-1:0] a_rem;
            logic [DW-1:0] a_work;
            logic [VW-1:0] a_dsr;
            logic [SW-1:0] a_side;
            logic [VW-1:0] n_rem;
            logic [DW-1:0] n_work;

            // Stage inputs: the port for the first stage, the previous stage otherwise
            if (s == 0) begin : g_first
                assign a_v    = i_valid;
                assign a_rem  = '0;
                assign a_work = i_dividend;
                assign a_dsr  = i_divisor;
                assign a_side = i_side;
            end else begin : g_next
                assign a_v    = r_v[s-1];
                assign a_rem  = r_rem[s-1];
                assign a_work = r_work[s-1];
                assign a_dsr  = r_dsr[s-1];
                assign a_side = r_side[s-1];
            end

            // STEPS restoring steps on a narrow remainder
            always_comb begin
                logic [VW:0] trial;
                logic [VW:0] diff;
                n_rem  = a_rem;
                n_work = a_work;
                for (int i = 0; i < STEPS; i++) begin
                    trial = {n_rem, n_work[DW-1]};
                    diff  = trial - {1'b0, a_dsr};
                    if (trial >= {1'b0, a_dsr}) begin
                        n_rem  = diff[VW-1:0];
                        n_work = {n_work[DW-2:0], 1'b1};
                    end else begin
                        n_rem  = trial[VW-1:0];
                        n_work = {n_work[DW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_load[s]) begin
                    r_v[s] <= a_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_load[s] && a_v) begin
                    r_rem[s]  <= n_rem;
                    r_work[s] <= n_work;
                    r_dsr[s]  <= a_dsr;
                    r_side[s] <= a_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_quot  = r_work[NS-1];
    assign o_rem   = r_rem[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

### sv/ata_sector_address_translate.sv
// Top level of the ATA sector address translation block: config registers,
// limit check, two asat_div pipelines and the task-file output register. Uses asat_pkg.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  s        | in        | i_s_tvalid/o_s_tready | tuser: func; tdata: sector
//  m        | out       | o_m_tvalid/i_m_tready | tuser: accepted; tdata: five task bytes
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_addr: register, i_cfg_data: value
//
// One request per cycle unless the output stalls; the path runs through the front stage,
// the two dividers, each resolving P_DIV_BITS quotient bits per stage, and the output register.
// Synchronous reset clears the valid bits and loads the default geometry.
// A stalled output holds; each stage loads whenever the stage after it can move,
// so empty slots fill up behind a waiting result and nothing is dropped or repeated.
`timescale 1ns / 1ps

module ata_sector_address_translate
    import asat_pkg::*;
#(
    parameter int P_DIV_BITS = DIV_BPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [SECTOR_W-1:0]  i_s_tdata,   // [31:0] sector
    input  logic [0:0]           i_s_tuser,   // [0] func (1 = write)
    // task-file stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // [7:0] device_head, [15:8] sector_number,
                                              // [23:16] cylinder_low, [31:24] cylinder_high,
                                              // [39:32] command
    output logic [0:0]           o_m_tuser,   // [0] accepted
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [SECTOR_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic                r_lba_mode;
    logic [SPT_W-1:0]    r_spt;
    logic [HC_W-1:0]     r_hc;
    logic [SECTOR_W-1:0] r_limit;
    logic                r_slave;
    logic                r_cd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba_mode <= 1'b0;
            r_spt      <= SPT_RESET;
            r_hc       <= HC_RESET;
            r_limit    <= '0;
            r_slave    <= 1'b0;
            r_cd       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LBA_MODE:     r_lba_mode <= i_cfg_data[0];
                CFG_SPT:          r_spt      <= i_cfg_data[SPT_W-1:0];
                CFG_HEAD_COUNT:   r_hc       <= i_cfg_data[HC_W-1:0];
                CFG_SECTOR_LIMIT: r_limit    <= i_cfg_data;
                CFG_SLAVE_SELECT: r_slave    <= i_cfg_data[0];
                CFG_CD_DEVICE:    r_cd       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Zero geometry acts as one
    logic [SPT_W-1:0] w_spt_eff;
    logic [HC_W-1:0]  w_hc_eff;
    assign w_spt_eff = (r_spt == '0) ? SPT_W'(1) : r_spt;
    assign w_hc_eff  = (r_hc == '0)  ? HC_W'(1)  : r_hc;

    // Front stage: limit and CD write checks
    logic   r_in_v;
    t_side1 r_in_side;
    t_side1 n_in_side;
    logic   w_in_load;
    logic   w_d1_ready;

    assign w_in_load  = !r_in_v || w_d1_ready;
    assign o_s_tready = w_in_load;

    always_comb begin
        n_in_side.ok     = !(i_s_tdata > r_limit) && !(i_s_tuser[0] && r_cd);
        n_in_side.func   = i_s_tuser[0];
        n_in_side.sector = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_load) begin
            r_in_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_s_tvalid) begin
            r_in_side <= n_in_side;
        end
    end

    // Sector / sectors per track
    logic                d1_valid;
    logic                w_d2_ready;
    logic [SECTOR_W-1:0] d1_quot;
    logic [SPT_W-1:0]    d1_rem;
    t_side1              d1_side;

    asat_div #(
        .DW  (SECTOR_W),
        .VW  (SPT_W),
        .SW  ($bits(t_side1)),
        .BPS (P_DIV_BITS)
    ) u_div_spt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_v),
        .o_ready    (w_d1_ready),
        .i_dividend (r_in_side.sector),
        .i_divisor  (w_spt_eff),
        .i_side     (r_in_side),
        .o_valid    (d1_valid),
        .i_ready    (w_d2_ready),
        .o_quot     (d1_quot),
        .o_rem      (d1_rem),
        .o_side     (d1_side)
    );

    // Track / head count
    t_side2              w_d2_in_side;
    logic                d2_valid;
    logic                w_out_load;
    logic [SECTOR_W-1:0] d2_quot;
    logic [HC_W-1:0]     d2_rem;
    t_side2              d2_side;

    always_comb begin
        w_d2_in_side.ok     = d1_side.ok;
        w_d2_in_side.func   = d1_side.func;
        w_d2_in_side.sector = d1_side.sector;
        w_d2_in_side.srem   = d1_rem;
    end

    asat_div #(
        .DW  (SECTOR_W),
        .VW  (HC_W),
        .SW  ($bits(t_side2)),
        .BPS (P_DIV_BITS)
    ) u_div_hc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d1_valid),
        .o_ready    (w_d2_ready),
        .i_dividend (d1_quot),
        .i_divisor  (w_hc_eff),
        .i_side     (w_d2_in_side),
        .o_valid    (d2_valid),
        .i_ready    (w_out_load),
        .o_quot     (d2_quot),
        .o_rem      (d2_rem),
        .o_side     (d2_side)
    );

    // Output stage: assemble the task-file bytes
    logic              r_out_v;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_user;
    logic [OUT_W-1:0]  n_out_data;

    assign w_out_load = !r_out_v || i_m_tready;

    always_comb begin
        logic [BYTE_W-1:0] base;
        logic [3:0]        head;
        logic [BYTE_W-1:0] secreg;
        logic [CYL_W-1:0]  cyl;
        logic [BYTE_W-1:0] dev_head;
        logic [BYTE_W-1:0] cmd;
        if (r_lba_mode) begin
            base   = BASE_LBA;
            head   = d2_side.sector[27:24];
            secreg = d2_side.sector[7:0];
            cyl    = d2_side.sector[23:8];
        end else begin
            base   = BASE_CHS;
            head   = d2_rem[3:0];
            secreg = d2_side.srem + SPT_W'(1);
            cyl    = d2_quot[CYL_W-1:0];
        end
        dev_head = base + {4'b0000, head} + (r_slave ? SLAVE_BIT : '0);
        cmd      = d2_side.func ? CMD_WRITE : CMD_READ;
        if (d2_side.ok) begin
            n_out_data = {cmd, cyl[15:8], cyl[7:0], secreg, dev_head};
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && d2_valid) begin
            r_out_data <= n_out_data;
            r_out_user <= d2_side.ok;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_user;

endmodule

### sv/asat_chk.sv
// Port-level checker for ata_sector_address_translate, bound to the top level.
// Uses asat_pkg and the assertion macros in ata_sector_address_translate_defines.svh.
`timescale 1ns / 1ps
`include "ata_sector_address_translate_defines.svh"

module asat_chk
    import asat_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,   // [7:0] device_head ... [39:32] command
    input logic [0:0]       o_m_tuser    // [0] accepted
);

    // A held result keeps its bytes until the transfer
    `ASAT_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // Rejected requests carry all-zero task-file bytes
    `ASAT_ASSERT_NOW(a_reject_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0, "rejected result not zeroed")

    // Accepted requests carry a read or write command
    `ASAT_ASSERT_NOW(a_cmd_code, o_m_tvalid && o_m_tuser[0], o_m_tdata[39:32] == CMD_READ || o_m_tdata[39:32] == CMD_WRITE, "bad command byte")

    // Device/head keeps its fixed high bits on accepted requests
    `ASAT_ASSERT_NOW(a_dev_head, o_m_tvalid && o_m_tuser[0], o_m_tdata[7] && o_m_tdata[5], "device/head base bits missing")

endmodule

bind ata_sector_address_translate asat_chk u_asat_chk (.*);

### tb/ata_sector_address_translate_tb.sv
// Self-checking testbench for ata_sector_address_translate: CHS/LBA task-file translation.
// Needs asat_pkg and the block's RTL only; request driver, ready driver and result
// checker are clocked always blocks fed by one stimulus initial block.
`timescale 1ns / 1ps

module ata_sector_address_translate_tb;
    import asat_pkg::*;

    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_CYCLES = 40;    // a little over twice the pipeline depth
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 75;

    typedef struct packed {
        logic                func;
        logic [SECTOR_W-1:0] sector;
    } sector_req_t;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] device_head;
        logic [BYTE_W-1:0] sector_number;
        logic [BYTE_W-1:0] cylinder_low;
        logic [BYTE_W-1:0] cylinder_high;
        logic [BYTE_W-1:0] command;
    } taskfile_t;

    // DUT ports; the inputs are known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [SECTOR_W-1:0]  i_s_tdata   = '0;
    logic [0:0]           i_s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic [0:0]           o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [SECTOR_W-1:0]  i_cfg_data  = '0;

    // Shadow of the configuration registers
    logic                mode_lba   = 1'b0;
    logic [SPT_W-1:0]    geo_spt    = SPT_RESET;
    logic [HC_W-1:0]     geo_heads  = HC_RESET;
    logic [SECTOR_W-1:0] max_sector = '0;
    logic                slave_sel  = 1'b0;
    logic                cd_present = 1'b0;

    sector_req_t pending_requests[$];
    taskfile_t   expected_taskfiles[$];

    int  n_queued    = 0;
    int  n_checked   = 0;
    int  n_mismatch  = 0;
    int  n_granted   = 0;
    int  n_refused   = 0;
    int  n_settings  = 0;
    int  src_gap     = 0;
    int  snk_gap     = 0;
    bit  src_idle_en = 1'b0;
    bit  snk_idle_en = 1'b0;

    ata_sector_address_translate u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected task-file bytes for one request under the current register shadow
    function automatic taskfile_t translate_request(logic func, logic [SECTOR_W-1:0] sector);
        taskfile_t         tf;
        logic [31:0]       spt, heads, track, cyl;
        logic [BYTE_W-1:0] head, secreg, base;
        tf = '0;
        // out of range, or a write to a CD: all bytes zero
        if (sector > max_sector || (func && cd_present))
            return tf;
        if (!mode_lba) begin
            // zero geometry counts as one
            spt    = (geo_spt == '0) ? 32'd1 : {24'd0, geo_spt};
            heads  = (geo_heads == '0) ? 32'd1 : {27'd0, geo_heads};
            track  = sector / spt;
            secreg = 8'(sector % spt + 32'd1);
            head   = 8'(track % heads);
            cyl    = (track / heads) & 32'h0000_FFFF;
            base   = BASE_CHS;
        end else begin
            secreg = sector[7:0];
            cyl    = {16'd0, sector[23:8]};
            head   = {4'd0, sector[27:24]};
            base   = BASE_LBA;
        end
        tf.accepted      = 1'b1;
        tf.device_head   = base + (head & 8'h0F) + (slave_sel ? SLAVE_BIT : 8'h00);
        tf.sector_number = secreg;
        tf.cylinder_low  = cyl[7:0];
        tf.cylinder_high = cyl[15:8];
        tf.command       = func ? CMD_WRITE : CMD_READ;
        return tf;
    endfunction

    // Request driver: predicts on every transfer, idles in bursts when enabled
    always @(posedge i_clk) begin : drive_requests
        sector_req_t req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_taskfiles.push_back(translate_request(i_s_tuser[0], i_s_tdata));
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (src_idle_en && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 9);
                    i_s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    req = pending_requests.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= req.sector;
                    i_s_tuser  <= req.func;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result-side ready with random stall bursts
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap--;
            i_m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge i_clk) begin : check_taskfiles
        taskfile_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser[0], o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[23:16],
                   o_m_tdata[31:24], o_m_tdata[39:32]};
            if (expected_taskfiles.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] unexpected transfer: tuser %b tdata %h",
                             $time, o_m_tuser, o_m_tdata);
            end else begin
                want = expected_taskfiles.pop_front();
                n_checked++;
                if (want.accepted)
                    n_granted++;
                else
                    n_refused++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("[%0t] mismatch (exp/got): accepted %b/%b dev_head %h/%h ",
                                 $time, want.accepted, got.accepted,
                                 want.device_head, got.device_head,
                                 "sector %h/%h cyl_lo %h/%h cyl_hi %h/%h cmd %h/%h",
                                 want.sector_number, got.sector_number,
                                 want.cylinder_low, got.cylinder_low,
                                 want.cylinder_high, got.cylinder_high,
                                 want.command, got.command);
                end
            end
        end
    end

    task automatic queue_request(logic func, logic [SECTOR_W-1:0] sector);
        pending_requests.push_back('{func: func, sector: sector});
        n_queued++;
    endtask

    // Returns at a rising edge once every queued request has its result
    task automatic wait_idle();
        do @(posedge i_clk); while (n_checked != n_queued);
    endtask

    // Writes all six registers; call at a rising edge with the block idle
    task automatic set_config(logic lba, logic [SPT_W-1:0] spt, logic [HC_W-1:0] heads,
                              logic [SECTOR_W-1:0] limit, logic slave, logic cd);
        logic [SECTOR_W-1:0] vals [6];
        t_cfg_idx            idx;
        vals[0] = {31'd0, lba};
        vals[1] = {24'd0, spt};
        vals[2] = {27'd0, heads};
        vals[3] = limit;
        vals[4] = {31'd0, slave};
        vals[5] = {31'd0, cd};
        for (int i = 0; i < 6; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_LBA_MODE:     mode_lba   = vals[i][0];
                CFG_SPT:          geo_spt    = vals[i][SPT_W-1:0];
                CFG_HEAD_COUNT:   geo_heads  = vals[i][HC_W-1:0];
                CFG_SECTOR_LIMIT: max_sector = vals[i];
                CFG_SLAVE_SELECT: slave_sel  = vals[i][0];
                CFG_CD_DEVICE:    cd_present = vals[i][0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Stimulus: directed corners, then randomized register settings
    initial begin : stimulus
        logic                func;
        logic [SECTOR_W-1:0] sector, limit;
        logic [SPT_W-1:0]    spt;
        logic [HC_W-1:0]     heads;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;

        // reset settings: only sector zero is in range
        queue_request(1'b0, 32'd0);
        queue_request(1'b1, 32'd0);
        queue_request(1'b0, 32'd1);
        queue_request(1'b1, 32'hFFFF_FFFF);

        // CHS 63x16, slave drive: track and head boundaries, cylinder overflow
        wait_idle();
        set_config(1'b0, 8'd63, 5'd16, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_request(1'b0, 32'd62);
        queue_request(1'b0, 32'd63);
        queue_request(1'b1, 32'd1007);
        queue_request(1'b0, 32'd1008);
        queue_request(1'b1, 32'hFFFF_FFFF);

        // zero geometry treated as one; CD refuses writes
        wait_idle();
        set_config(1'b0, 8'd0, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        queue_request(1'b0, 32'hFFFF_FFFF);
        queue_request(1'b0, 32'h0001_0000);
        queue_request(1'b1, 32'd5);

        // head count above sixteen, largest sectors per track
        wait_idle();
        set_config(1'b0, 8'd255, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_request(1'b0, 32'd255 * 32'd17 + 32'd3);
        queue_request(1'b1, 32'hFFFF_FFFF);
        queue_request(1'b0, 32'd254);

        // LBA with a 28-bit limit, CD device
        wait_idle();
        set_config(1'b1, 8'd1, 5'd1, 32'h0FFF_FFFF, 1'b0, 1'b1);
        queue_request(1'b0, 32'h0ABC_DEF1);
        queue_request(1'b0, 32'h0FFF_FFFF);
        queue_request(1'b0, 32'h1000_0000);
        queue_request(1'b1, 32'd0);

        // LBA full range, slave drive
        wait_idle();
        set_config(1'b1, 8'd63, 5'd16, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_request(1'b1, 32'hFFFF_FFFF);
        queue_request(1'b0, 32'hA5A5_5A5A);

        // random settings, each followed by a batch of requests
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0:       spt = 8'd0;
                1:       spt = 8'd1;
                2:       spt = 8'd255;
                default: spt = 8'($urandom_range(0, 255));
            endcase
            heads = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 5))
                0, 1:    limit = 32'hFFFF_FFFF;
                2:       limit = $urandom;
                3:       limit = $urandom_range(0, 65535);
                4:       limit = $urandom_range(0, 300);
                default: limit = 32'd0;
            endcase
            set_config(1'($urandom_range(0, 1)), spt, heads, limit,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0));
            // no idling at all in the final batch
            src_idle_en = (p != N_PHASES - 1) && (p % 4 != 3);
            snk_idle_en = (p != N_PHASES - 1) && (p % 3 != 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender holds off until the pipeline has drained
                if (k == PHASE_ITEMS / 2 && p % 2 == 1)
                    wait_idle();
                func = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       sector = 32'd0;
                    1:       sector = 32'hFFFF_FFFF;
                    2:       sector = limit;
                    3:       sector = limit + 32'd1;
                    4:       sector = $urandom;
                    5:       sector = $urandom_range(0, 4095);
                    default: sector = $urandom_range(limit, 0);
                endcase
                queue_request(func, sector);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Translated %0d requests (%0d accepted, %0d refused) over %0d register settings",
                 n_checked, n_granted, n_refused, n_settings);
        $display("CHS and LBA modes, zero and oversized geometry, limit and CD refusals covered");
        if (n_mismatch == 0 && expected_taskfiles.size() == 0 && pending_requests.size() == 0)
            $display("Test completed successfully");
        else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, expected_taskfiles.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout: %0d of %0d results seen", n_checked, n_queued);
        $display("Test completed with failures");
        $finish;
    end

endmodule
